@@ sv/aabb_elastic_collision_resolve_assert.svh @@
// Assertion macros for the collision resolve block
`ifndef AABB_ELASTIC_COLLISION_RESOLVE_ASSERT_SVH
`define AABB_ELASTIC_COLLISION_RESOLVE_ASSERT_SVH
`ifndef SYNTHESIS
`define AECR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define AECR_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define AECR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define AECR_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ sv/aecr_pkg.sv @@
// Shared constants and types for the collision resolve block
package aecr_pkg;
  localparam int COMPONENT_BITS = 16;
  localparam int MASS_W         = 16;
  localparam int SUM_W          = MASS_W + 1;
  localparam int THR_W          = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd26;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 1;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;
endpackage

@@ sv/aecr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband
module aecr_div #(
  parameter int NW = 35,
  parameter int DW = 17,
  parameter int SW = 18
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic [NW-1:0] n_st [1:NW];
  logic [NW-1:0] q_st [1:NW];
  logic [DW-1:0] r_st [1:NW];
  logic [DW-1:0] d_st [1:NW];
  logic [SW-1:0] s_st [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
      assign s_in = side;
    end else begin : g_rest
      assign n_in = n_st[k];
      assign q_in = q_st[k];
      assign r_in = r_st[k];
      assign d_in = d_st[k];
      assign s_in = s_st[k];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      n_st[k+1] <= {n_in[NW-2:0], 1'b0};
      q_st[k+1] <= {q_in[NW-2:0], ge};
      r_st[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      d_st[k+1] <= d_in;
      s_st[k+1] <= s_in;
    end
  end

  assign quo      = q_st[NW];
  assign side_out = s_st[NW];
endmodule

@@ sv/aecr_lane.sv @@
// One axis lane: elastic velocity update for both bodies on one component
module aecr_lane #(
  parameter int CB = aecr_pkg::COMPONENT_BITS
) (
  input  logic                        clk,
  input  logic signed [CB-1:0]        a_vel,
  input  logic signed [CB-1:0]        b_vel,
  input  logic [aecr_pkg::MASS_W-1:0] a_mass,
  input  logic [aecr_pkg::MASS_W-1:0] b_mass,
  input  logic                        hold,
  output logic [CB-1:0]               a_new,
  output logic [CB-1:0]               b_new
);
  localparam int SW_M = aecr_pkg::SUM_W;
  localparam int PW   = CB + SW_M;
  localparam int NW   = CB + 19;
  localparam int SDW  = CB + 2;

  logic signed [SW_M-1:0] dm;
  logic signed [PW-1:0]   av_x, bv_x, dm_x, ma_x, mb_x;
  logic [SW_M-1:0]        msum;

  logic signed [PW-1:0] s1_pa1, s1_pa2, s1_pb1, s1_pb2;
  logic [SW_M-1:0]      s1_msum;
  logic                 s1_hold;
  logic [CB-1:0]        s1_va, s1_vb;

  logic signed [NW-1:0] num_a, num_b;
  logic [NW-1:0]        s2_mag_a, s2_mag_b;
  logic                 s2_neg_a, s2_neg_b;
  logic [SW_M-1:0]      s2_msum;
  logic                 s2_hold;
  logic [CB-1:0]        s2_va, s2_vb;

  logic [NW-1:0]  quo_a, quo_b;
  logic [SDW-1:0] side_a, side_b;
  logic signed [NW:0] res_a, res_b;
  logic [CB-1:0]  sat_a, sat_b;

  assign dm   = $signed({1'b0, a_mass}) - $signed({1'b0, b_mass});
  assign msum = {1'b0, a_mass} + {1'b0, b_mass};
  assign av_x = PW'(a_vel);
  assign bv_x = PW'(b_vel);
  assign dm_x = PW'(dm);
  assign ma_x = $signed(PW'({1'b0, a_mass}));
  assign mb_x = $signed(PW'({1'b0, b_mass}));

  always_ff @(posedge clk) begin
    s1_pa1  <= av_x * dm_x;
    s1_pa2  <= mb_x * bv_x;
    s1_pb1  <= bv_x * (-dm_x);
    s1_pb2  <= ma_x * av_x;
    s1_msum <= msum;
    s1_hold <= hold || (msum == '0);
    s1_va   <= a_vel;
    s1_vb   <= b_vel;
  end

  assign num_a = NW'(s1_pa1) + (NW'(s1_pa2) <<< 1);
  assign num_b = NW'(s1_pb1) + (NW'(s1_pb2) <<< 1);

  always_ff @(posedge clk) begin
    s2_neg_a <= num_a[NW-1];
    s2_neg_b <= num_b[NW-1];
    s2_mag_a <= num_a[NW-1] ? NW'(-num_a) : NW'(num_a);
    s2_mag_b <= num_b[NW-1] ? NW'(-num_b) : NW'(num_b);
    s2_msum  <= s1_msum;
    s2_hold  <= s1_hold;
    s2_va    <= s1_va;
    s2_vb    <= s1_vb;
  end

  aecr_div #(.NW(NW), .DW(SW_M), .SW(SDW)) u_div_a (
    .clk      (clk),
    .num      (s2_mag_a),
    .den      (s2_msum),
    .side     ({s2_neg_a, s2_hold, s2_va}),
    .quo      (quo_a),
    .side_out (side_a)
  );

  aecr_div #(.NW(NW), .DW(SW_M), .SW(SDW)) u_div_b (
    .clk      (clk),
    .num      (s2_mag_b),
    .den      (s2_msum),
    .side     ({s2_neg_b, s2_hold, s2_vb}),
    .quo      (quo_b),
    .side_out (side_b)
  );

  assign res_a = side_a[SDW-1] ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
  assign res_b = side_b[SDW-1] ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});

  always_comb begin
    if ((&res_a[NW:CB-1]) || !(|res_a[NW:CB-1])) begin
      sat_a = res_a[CB-1:0];
    end else begin
      sat_a = {res_a[NW], {(CB-1){~res_a[NW]}}};
    end
    if ((&res_b[NW:CB-1]) || !(|res_b[NW:CB-1])) begin
      sat_b = res_b[CB-1:0];
    end else begin
      sat_b = {res_b[NW], {(CB-1){~res_b[NW]}}};
    end
  end

  always_ff @(posedge clk) begin
    a_new <= side_a[SDW-2] ? side_a[CB-1:0] : sat_a;
    b_new <= side_b[SDW-2] ? side_b[CB-1:0] : sat_b;
  end
endmodule

@@ sv/aabb_elastic_collision_resolve.sv @@
// Top level: overlap test, push-out merge, three velocity lanes, register port
//
//  channel   direction  handshake                    payload
//  command   in         start, busy                  boxes, positions, velocities, masses
//  result    out        done (one-cycle strobe)      new velocities, new positions, resolved
//  config    in         psel, penable, pwrite, pready overlap_threshold at address 0
//
// One transaction enters every cycle; busy is always low.
// Each result passes through the pipelined divider of COMPONENT_BITS + 19
// stages in each lane.
// Reset clears the threshold to its default and empties the valid pipeline.
// The receiver cannot stall; results leave on done regardless.
`include "aabb_elastic_collision_resolve_assert.svh"
module aabb_elastic_collision_resolve #(
  parameter int COMPONENT_BITS = aecr_pkg::COMPONENT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [3*COMPONENT_BITS-1:0]     a_box_min,
  input  logic [3*COMPONENT_BITS-1:0]     a_box_max,
  input  logic [3*COMPONENT_BITS-1:0]     b_box_min,
  input  logic [3*COMPONENT_BITS-1:0]     b_box_max,
  input  logic [3*COMPONENT_BITS-1:0]     a_position,
  input  logic [3*COMPONENT_BITS-1:0]     b_position,
  input  logic [3*COMPONENT_BITS-1:0]     a_velocity,
  input  logic [3*COMPONENT_BITS-1:0]     b_velocity,
  input  logic [aecr_pkg::MASS_W-1:0]     a_mass,
  input  logic [aecr_pkg::MASS_W-1:0]     b_mass,
  output logic                            done,
  output logic [3*COMPONENT_BITS-1:0]     a_new_velocity,
  output logic [3*COMPONENT_BITS-1:0]     b_new_velocity,
  output logic [3*COMPONENT_BITS-1:0]     a_new_position,
  output logic [3*COMPONENT_BITS-1:0]     b_new_position,
  output logic                            resolved,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aecr_pkg::ADDR_W-1:0]     paddr,
  input  logic [aecr_pkg::DATA_W-1:0]     pwdata,
  output logic [aecr_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  localparam int CB  = COMPONENT_BITS;
  localparam int VW  = 3 * CB;
  localparam int OW  = CB + 1;
  localparam int CW  = ((OW > aecr_pkg::THR_W) ? OW : aecr_pkg::THR_W) + 1;
  localparam int NW  = CB + 19;
  localparam int LAT = NW + 3;
  localparam int DL  = NW + 2;

  logic [aecr_pkg::THR_W-1:0] threshold;
  logic                       accept;
  logic [2:0]                 hit;
  logic                       any_hit;
  logic signed [OW-1:0]       ov [3];

  logic                 s1_any;
  logic signed [OW-1:0] s1_ov [3];
  logic [VW-1:0]        s1_pa, s1_pb;

  aecr_pkg::axis_t      sel;
  logic signed [OW-1:0] h;
  logic signed [OW-1:0] d;
  logic [VW-1:0]        pa_new, pb_new;

  logic [VW-1:0] dl_pa  [DL];
  logic [VW-1:0] dl_pb  [DL];
  logic          dl_any [DL];
  logic [LAT-1:0] vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = aecr_pkg::DATA_W'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= aecr_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == aecr_pkg::ADDR_THRESHOLD) begin
      threshold <= pwdata[aecr_pkg::THR_W-1:0];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [OW-1:0] d1, d2;
    assign d1 = OW'($signed(a_box_max[k*CB +: CB])) - OW'($signed(b_box_min[k*CB +: CB]));
    assign d2 = OW'($signed(b_box_max[k*CB +: CB])) - OW'($signed(a_box_min[k*CB +: CB]));
    assign ov[k]  = (d1 < d2) ? d1 : d2;
    assign hit[k] = CW'(ov[k]) >= $signed(CW'({1'b0, threshold}));

    aecr_lane #(.CB(CB)) u_lane (
      .clk    (clk),
      .a_vel  ($signed(a_velocity[k*CB +: CB])),
      .b_vel  ($signed(b_velocity[k*CB +: CB])),
      .a_mass (a_mass),
      .b_mass (b_mass),
      .hold   (!any_hit),
      .a_new  (a_new_velocity[k*CB +: CB]),
      .b_new  (b_new_velocity[k*CB +: CB])
    );
  end

  assign any_hit = |hit;

  always_ff @(posedge clk) begin
    s1_any <= any_hit;
    s1_ov  <= ov;
    s1_pa  <= a_position;
    s1_pb  <= b_position;
  end

  always_comb begin
    priority if (s1_ov[0] <= s1_ov[1] && s1_ov[0] <= s1_ov[2]) begin
      sel = aecr_pkg::AXIS_X;
    end else if (s1_ov[1] <= s1_ov[2]) begin
      sel = aecr_pkg::AXIS_Y;
    end else begin
      sel = aecr_pkg::AXIS_Z;
    end
    h = s1_ov[sel] >>> 1;
    d = OW'($signed(s1_pa[sel*CB +: CB])) - OW'($signed(s1_pb[sel*CB +: CB]));
  end

  for (genvar k = 0; k < 3; k++) begin : g_push
    logic signed [OW:0] ap, bp;
    logic [CB-1:0]      ap_sat, bp_sat;
    assign ap = (OW+1)'($signed(s1_pa[k*CB +: CB])) + ((d > 0) ? (OW+1)'(h) : -(OW+1)'(h));
    assign bp = (OW+1)'($signed(s1_pb[k*CB +: CB])) + ((d < 0) ? (OW+1)'(h) : -(OW+1)'(h));
    always_comb begin
      if ((&ap[OW:CB-1]) || !(|ap[OW:CB-1])) begin
        ap_sat = ap[CB-1:0];
      end else begin
        ap_sat = {ap[OW], {(CB-1){~ap[OW]}}};
      end
      if ((&bp[OW:CB-1]) || !(|bp[OW:CB-1])) begin
        bp_sat = bp[CB-1:0];
      end else begin
        bp_sat = {bp[OW], {(CB-1){~bp[OW]}}};
      end
    end
    assign pa_new[k*CB +: CB] = (s1_any && sel == aecr_pkg::axis_t'(k)) ?
                                ap_sat : s1_pa[k*CB +: CB];
    assign pb_new[k*CB +: CB] = (s1_any && sel == aecr_pkg::axis_t'(k)) ?
                                bp_sat : s1_pb[k*CB +: CB];
  end

  always_ff @(posedge clk) begin
    dl_pa[0]  <= pa_new;
    dl_pb[0]  <= pb_new;
    dl_any[0] <= s1_any;
    for (int i = 1; i < DL; i++) begin
      dl_pa[i]  <= dl_pa[i-1];
      dl_pb[i]  <= dl_pb[i-1];
      dl_any[i] <= dl_any[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  assign done           = vld[LAT-1];
  assign a_new_position = dl_pa[DL-1];
  assign b_new_position = dl_pb[DL-1];
  assign resolved       = dl_any[DL-1];

  `AECR_ASSERT_IMPLIES(a_done_has_start, clk, rst, done, $past(accept, LAT))
  `AECR_ASSERT_IMPLIES(a_bypass_vel_a, clk, rst, done && !resolved, a_new_velocity == $past(a_velocity, LAT))
  `AECR_ASSERT_IMPLIES(a_bypass_vel_b, clk, rst, done && !resolved, b_new_velocity == $past(b_velocity, LAT))
  `AECR_ASSERT_IMPLIES(a_bypass_pos_a, clk, rst, done && !resolved, a_new_position == $past(a_position, LAT))
endmodule
